// File: hdl/wah_pkg.sv
// ----------------------------------------------------------------------------
// wah_pkg
// Shared widths, codes and defaults for the windowed amplitude histogram.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wah_pkg;

  // Default sizing of the counter store
  localparam int DEF_MAX_WINDOWS_LOG2 = 6;
  localparam int DEF_MAX_BINS         = 64;
  localparam int DEF_COUNT_WIDTH      = 32;

  // Transaction field widths
  localparam int KIND_W     = 2;
  localparam int SAMPLE_W   = 16;
  localparam int IDX_W      = 6;
  localparam int COUNT_W    = 32;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;

  // Configuration register widths and reset values
  localparam int LOG2_W  = 3;
  localparam int BINS_W  = 7;
  localparam int TOTAL_W = 30;

  localparam logic [LOG2_W-1:0]  LOG2_RST  = 3'd4;
  localparam logic [BINS_W-1:0]  BINS_RST  = 7'd16;
  localparam logic [TOTAL_W-1:0] TOTAL_RST = 30'd1024;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL       = 2'd2;

  // Amplitude mapping: u = s + 32767, bin = floor(u * m / 65534)
  localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN    = 16'h8000;
  localparam int                  HALF_SPAN_LOG2 = 15;      // 65534 = 2 * (2^15 - 1)
  localparam int                  HALF_SPAN      = 32767;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_COUNTED = 3'd0,
    ST_SKIP    = 3'd1,
    ST_PAST    = 3'd2,
    ST_RANGE   = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

endpackage

`default_nettype wire

// File: hdl/wah_in_if.sv
// ----------------------------------------------------------------------------
// wah_in_if
// Item channel: sample, read and clear requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wah_in_if import wah_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic signed [SAMPLE_W-1:0] sample;
  logic [IDX_W-1:0]           window_index;
  logic [IDX_W-1:0]           bin_index;

  modport source (output valid, kind, sample, window_index, bin_index, input ready);
  modport sink   (input valid, kind, sample, window_index, bin_index, output ready);
endinterface

`default_nettype wire

// File: hdl/wah_out_if.sv
// ----------------------------------------------------------------------------
// wah_out_if
// Result channel: counter location, value and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wah_out_if import wah_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    window_out;
  logic [IDX_W-1:0]    bin_out;
  logic [COUNT_W-1:0]  count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, window_out, bin_out, count, status, input ready);
  modport sink   (input valid, window_out, bin_out, count, status, output ready);
endinterface

`default_nettype wire

// File: hdl/wah_cfg_if.sv
// ----------------------------------------------------------------------------
// wah_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wah_cfg_if import wah_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/wah_divider.sv
// ----------------------------------------------------------------------------
// wah_divider
// Restoring divider for the time window: (index << nlog) / total, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wah_divider import wah_pkg::*; #(
  parameter int MAX_WINDOWS_LOG2 = DEF_MAX_WINDOWS_LOG2
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [TOTAL_W-1:0]                    index,
  input  logic [TOTAL_W-1:0]                    total,
  input  logic [((MAX_WINDOWS_LOG2 > 0) ? $clog2(MAX_WINDOWS_LOG2 + 1) : 1)-1:0] nlog,
  output logic                                  done,
  output logic [((MAX_WINDOWS_LOG2 > 0) ? MAX_WINDOWS_LOG2 : 1)-1:0] quot
);

  localparam int QW   = (MAX_WINDOWS_LOG2 > 0) ? MAX_WINDOWS_LOG2 : 1;
  localparam int PW   = TOTAL_W + QW;
  localparam int CNTW = $clog2(QW + 1);

  logic [PW-1:0]   rem_r;
  logic [PW-1:0]   dsr_r;
  logic [QW-1:0]   quot_r;
  logic [CNTW-1:0] cnt_r;
  logic            done_r;
  logic            ge;
  logic [QW:0]     quot_sh;

  assign ge      = (rem_r >= dsr_r);
  assign quot_sh = {quot_r, ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNTW'(QW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= PW'(index) << nlog;
      dsr_r  <= PW'(total) << (QW - 1);
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      if (ge) begin
        rem_r <= rem_r - dsr_r;
      end
      dsr_r  <= dsr_r >> 1;
      quot_r <= quot_sh[QW-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

// File: hdl/wah_binmap.sv
// ----------------------------------------------------------------------------
// wah_binmap
// Amplitude bin of a sample: floor((s + 32767) * m / 65534), clamped to m-1.
// Two stages: multiply, then constant division by 2 * (2^15 - 1).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wah_binmap import wah_pkg::*; #(
  parameter int MAX_BINS = DEF_MAX_BINS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [SAMPLE_W-1:0]                 sample,
  input  logic [$clog2(MAX_BINS + 1)-1:0]     m,
  output logic [$clog2(MAX_BINS)-1:0]         bin
);

  localparam int BW  = $clog2(MAX_BINS + 1);
  localparam int BIW = $clog2(MAX_BINS);
  localparam int PW  = SAMPLE_W + BW;
  localparam int RW  = ((BW > HALF_SPAN_LOG2) ? BW : HALF_SPAN_LOG2) + 1;

  logic [PW-1:0]       prod_r;
  logic [BW-1:0]       m_r;
  logic                vld_r;
  logic [BIW-1:0]      bin_r;
  logic [SAMPLE_W-1:0] u;
  logic [PW-2:0]       y;
  logic [BW-1:0]       q0;
  logic [RW-1:0]       r;
  logic [BW-1:0]       q;
  logic [BW-1:0]       q_clamp;

  // Wraps to s + 32767 for every sample above the minimum
  assign u = sample + SAMPLE_OFFSET;

  // y / (2^15 - 1): quotient y >> 15, remainder low bits plus that quotient,
  // which stays below twice the divisor, so one correction step suffices.
  assign y       = prod_r[PW-1:1];
  assign q0      = y[PW-2:HALF_SPAN_LOG2];
  assign r       = RW'(y[HALF_SPAN_LOG2-1:0]) + RW'(q0);
  assign q       = (r >= RW'(HALF_SPAN)) ? q0 + 1'b1 : q0;
  assign q_clamp = (q >= m_r) ? m_r - 1'b1 : q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PW'(u) * PW'(m);
      m_r    <= m;
    end
    if (vld_r) begin
      bin_r <= BIW'(q_clamp);
    end
  end

  assign bin = bin_r;

endmodule

`default_nettype wire

// File: hdl/wah_store.sv
// ----------------------------------------------------------------------------
// wah_store
// Counter memory: one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wah_store import wah_pkg::*; #(
  parameter int DEPTH       = (1 << DEF_MAX_WINDOWS_LOG2) * DEF_MAX_BINS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [COUNT_WIDTH-1:0]   wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [COUNT_WIDTH-1:0]   rdata
);

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hdl/windowed_amplitude_histogram.sv
// ----------------------------------------------------------------------------
// windowed_amplitude_histogram
// Two-dimensional histogram (time window x amplitude bin) of 16-bit audio
// samples held in one counter memory. Items are handled one at a time. A
// sample passes the window divider, which takes Q steps, where
// Q = MAX_WINDOWS_LOG2 (at least 1), and then the memory read-modify-write.
// A minimum sample touches no counter. A read only reads the memory, and a
// sample past the total or a read out of range goes straight to its result.
// A clear zeroes the memory one entry per cycle, all 2^MAX_WINDOWS_LOG2 *
// MAX_BINS entries (4096 by default), and the same sweep runs after reset
// with the item channel held off. The result register lets the next item be
// taken while a result waits. Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module windowed_amplitude_histogram import wah_pkg::*; #(
  parameter int MAX_WINDOWS_LOG2 = DEF_MAX_WINDOWS_LOG2,
  parameter int MAX_BINS         = DEF_MAX_BINS,
  parameter int COUNT_WIDTH      = DEF_COUNT_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  wah_in_if.sink    in_ch,
  wah_out_if.source out_ch,
  wah_cfg_if.sink   cfg_ch
);

  localparam int QW    = (MAX_WINDOWS_LOG2 > 0) ? MAX_WINDOWS_LOG2 : 1;
  localparam int NLW   = (MAX_WINDOWS_LOG2 > 0) ? $clog2(MAX_WINDOWS_LOG2 + 1) : 1;
  localparam int BW    = $clog2(MAX_BINS + 1);
  localparam int BIW   = $clog2(MAX_BINS);
  localparam int DEPTH = (1 << MAX_WINDOWS_LOG2) * MAX_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_READ,
    S_UPD,
    S_OUT
  } state_t;

  state_t               state_r;
  kind_t                kind_r;
  logic                 min_r;
  logic                 clr_reply_r;
  logic [AW-1:0]        addr_r;
  logic [AW-1:0]        sweep_r;
  logic [TOTAL_W-1:0]   idx_r;
  logic [LOG2_W-1:0]    log2_r;
  logic [BINS_W-1:0]    bins_r;
  logic [TOTAL_W-1:0]   total_r;

  logic [IDX_W-1:0]     res_win_r;
  logic [IDX_W-1:0]     res_bin_r;
  logic [COUNT_W-1:0]   res_cnt_r;
  status_t              res_st_r;

  logic                 out_valid_r;
  logic [IDX_W-1:0]     out_win_r;
  logic [IDX_W-1:0]     out_bin_r;
  logic [COUNT_W-1:0]   out_cnt_r;
  status_t              out_st_r;

  logic                 in_acc;
  logic                 add_go;
  logic [NLW-1:0]       nlog;
  logic [BW-1:0]        m_eff;
  logic [IDX_W-1:0]     win_hi;
  logic                 rd_oor;
  logic                 div_done;
  logic [QW-1:0]        quot;
  logic [BIW-1:0]       bin_q;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [COUNT_WIDTH-1:0] mem_rdata;
  logic [COUNT_WIDTH-1:0] cnt_inc;

  // Effective register values
  assign nlog  = (int'(log2_r) > MAX_WINDOWS_LOG2) ? NLW'(MAX_WINDOWS_LOG2) : NLW'(log2_r);
  assign m_eff = (bins_r == '0)              ? BW'(1) :
                 (int'(bins_r) > MAX_BINS)   ? BW'(MAX_BINS) : BW'(bins_r);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign add_go      = in_acc && (kind_t'(in_ch.kind) == KIND_ADD) && (idx_r < total_r);

  assign win_hi = in_ch.window_index >> nlog;
  assign rd_oor = (win_hi != '0) || (int'(in_ch.bin_index) >= int'(m_eff));

  assign cfg_ch.ready = 1'b1;

  wah_divider #(
    .MAX_WINDOWS_LOG2 (MAX_WINDOWS_LOG2)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (add_go),
    .index (idx_r),
    .total (total_r),
    .nlog  (nlog),
    .done  (div_done),
    .quot  (quot)
  );

  // Bin result passes the product and bin registers after acceptance and holds
  // until the next sample; the divider never finishes before it is ready.
  wah_binmap #(
    .MAX_BINS (MAX_BINS)
  ) u_bin (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (add_go),
    .sample (in_ch.sample),
    .m      (m_eff),
    .bin    (bin_q)
  );

  wah_store #(
    .DEPTH       (DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  assign cnt_inc = (&mem_rdata) ? mem_rdata : mem_rdata + COUNT_WIDTH'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = cnt_inc;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_r;
      mem_wdata = '0;
    end else if (state_r == S_UPD && kind_r == KIND_ADD) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = (state_r == S_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      clr_reply_r <= 1'b0;
      idx_r       <= '0;
      log2_r      <= LOG2_RST;
      bins_r      <= BINS_RST;
      total_r     <= TOTAL_RST;
      out_valid_r <= 1'b0;
    end else begin
      // S_OUT reloads the result register itself
      if (out_valid_r && out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_WINDOW_LOG2: log2_r  <= cfg_ch.data[LOG2_W-1:0];
          REG_BIN_COUNT:   bins_r  <= cfg_ch.data[BINS_W-1:0];
          REG_TOTAL:       total_r <= cfg_ch.data[TOTAL_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_CLEAR: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == LAST_ADDR) begin
            clr_reply_r <= 1'b0;
            if (clr_reply_r) begin
              res_win_r <= '0;
              res_bin_r <= '0;
              res_cnt_r <= '0;
              res_st_r  <= ST_CLEARED;
              state_r   <= S_OUT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            kind_r <= kind_t'(in_ch.kind);
            unique case (kind_t'(in_ch.kind))
              KIND_ADD: begin
                if (idx_r >= total_r) begin
                  res_win_r <= '0;
                  res_bin_r <= '0;
                  res_cnt_r <= '0;
                  res_st_r  <= ST_PAST;
                  state_r   <= S_OUT;
                end else begin
                  idx_r   <= idx_r + 1'b1;
                  min_r   <= (in_ch.sample == SAMPLE_MIN);
                  state_r <= S_CALC;
                end
              end
              KIND_READ: begin
                res_win_r <= in_ch.window_index;
                res_bin_r <= in_ch.bin_index;
                if (rd_oor) begin
                  res_cnt_r <= '0;
                  res_st_r  <= ST_RANGE;
                  state_r   <= S_OUT;
                end else begin
                  addr_r  <= AW'(in_ch.window_index) * AW'(MAX_BINS) + AW'(in_ch.bin_index);
                  state_r <= S_READ;
                end
              end
              KIND_CLEAR: begin
                idx_r       <= '0;
                sweep_r     <= '0;
                clr_reply_r <= 1'b1;
                state_r     <= S_CLEAR;
              end
              default: ;  // unused kind: dropped without a result
            endcase
          end
        end

        S_CALC: begin
          if (div_done) begin
            res_win_r <= IDX_W'(quot);
            if (min_r) begin
              res_bin_r <= '0;
              res_cnt_r <= '0;
              res_st_r  <= ST_SKIP;
              state_r   <= S_OUT;
            end else begin
              res_bin_r <= IDX_W'(bin_q);
              addr_r    <= AW'(quot) * AW'(MAX_BINS) + AW'(bin_q);
              state_r   <= S_READ;
            end
          end
        end

        S_READ: begin
          state_r <= S_UPD;
        end

        S_UPD: begin
          res_cnt_r <= COUNT_W'((kind_r == KIND_ADD) ? cnt_inc : mem_rdata);
          res_st_r  <= ST_COUNTED;
          state_r   <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_win_r   <= res_win_r;
            out_bin_r   <= res_bin_r;
            out_cnt_r   <= res_cnt_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.window_out = out_win_r;
  assign out_ch.bin_out    = out_bin_r;
  assign out_ch.count      = out_cnt_r;
  assign out_ch.status     = out_st_r;

endmodule

`default_nettype wire

// File: hdl/wah_checker.sv
// ----------------------------------------------------------------------------
// wah_checker
// Port-level checks for the windowed amplitude histogram, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wah_checker import wah_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [KIND_W-1:0]   in_kind,
  input logic                out_valid,
  input logic                out_ready,
  input logic [IDX_W-1:0]    out_window,
  input logic [IDX_W-1:0]    out_bin,
  input logic [COUNT_W-1:0]  out_count,
  input logic [STATUS_W-1:0] out_status
);

  // A stalled result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_window) && $stable(out_bin) &&
                                $stable(out_count) && $stable(out_status))
    else $error("result changed while stalled");

  // One item at a time: any real item closes the input after it is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_ADD || in_kind == KIND_READ ||
                             in_kind == KIND_CLEAR) |=> !in_ready)
    else $error("input taken while an item is in flight");

  // Skip, past-total and clear results carry no count and point at bin zero
  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_SKIP || out_status == ST_PAST ||
                  out_status == ST_CLEARED) |-> out_count == '0 && out_bin == '0)
    else $error("nonzero count on a result without a counter");

  // Past-total and clear results point at window zero
  a_zero_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_PAST || out_status == ST_CLEARED) |-> out_window == '0)
    else $error("nonzero window on a past-total or clear result");

endmodule

bind windowed_amplitude_histogram wah_checker u_wah_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_kind    (in_ch.kind),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_window (out_ch.window_out),
  .out_bin    (out_ch.bin_out),
  .out_count  (out_ch.count),
  .out_status (out_ch.status)
);

`default_nettype wire
